// ===== src/pps_pkg.sv =====
// Shared constants, types and state codes for the preemptive priority scheduler.
`timescale 1ns / 1ps
package pps_pkg;

    localparam int MAX_PROC = 16;
    localparam int IDX_W    = $clog2(MAX_PROC);
    localparam int CNT_W    = $clog2(MAX_PROC + 1);

    localparam int ID_W   = 8;
    localparam int TIME_W = 12;
    localparam int PRI_W  = 8;
    localparam int TICK_W = 17;
    localparam int SUM_W  = 21;

    // static record: id, arrival, burst, priority
    localparam int REC_W = ID_W + TIME_W + TIME_W + PRI_W;
    // dynamic record: remaining service, completion tick
    localparam int DYN_W = TIME_W + TICK_W;

    typedef enum logic [3:0] {
        ST_LOAD = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_UPD  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  idx;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic [TIME_W-1:0] remaining;
    } pps_best_t;

endpackage

// ===== src/pps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/pps_pick.sv =====
// Selection unit: tracks the best ready process over one table scan.
`timescale 1ns / 1ps
module pps_pick (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  logic                          in_valid,
    input  logic [pps_pkg::IDX_W-1:0]     in_idx,
    input  logic [pps_pkg::TIME_W-1:0]    in_arrival,
    input  logic [pps_pkg::TIME_W-1:0]    in_burst,
    input  logic [pps_pkg::PRI_W-1:0]     in_priority,
    input  logic [pps_pkg::TIME_W-1:0]    in_remaining,
    input  logic [pps_pkg::TICK_W-1:0]    tick,
    output pps_pkg::pps_best_t            best
);

    logic                            found_reg;
    logic [pps_pkg::IDX_W-1:0]       idx_reg;
    logic [pps_pkg::TIME_W-1:0]      arrival_reg;
    logic [pps_pkg::TIME_W-1:0]      burst_reg;
    logic [pps_pkg::TIME_W-1:0]      remaining_reg;
    logic [pps_pkg::PRI_W-1:0]       best_pri_reg;
    logic                            ready;
    logic                            better;

    // ready: arrived and still needs service
    assign ready = ({{(pps_pkg::TICK_W - pps_pkg::TIME_W){1'b0}}, in_arrival} <= tick)
                   && (in_remaining != '0);

    // higher priority wins; ties go to the earlier arrival, then load order
    assign better = !found_reg
                    || (in_priority > best_pri_reg)
                    || ((in_priority == best_pri_reg) && (in_arrival < arrival_reg));

    // hold found flag under reset, payload follows the winner
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (clear)
        begin
            found_reg <= 1'b0;
        end
        else if (in_valid && ready && better)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!clear && in_valid && ready && better)
        begin
            idx_reg       <= in_idx;
            arrival_reg   <= in_arrival;
            burst_reg     <= in_burst;
            remaining_reg <= in_remaining;
            best_pri_reg  <= in_priority;
        end
    end

    assign best = {found_reg, idx_reg, arrival_reg, burst_reg, remaining_reg};

endmodule

// ===== src/preemptive_priority_scheduler.sv =====
// Run: after the last record, each simulated tick scans the record RAMs, then updates
// the selected process. Results then stream one per cycle over the output scan.
// Throughput: one record per cycle while loading; busy stays high during the run.
// Reset: asynchronous active-low; clears counts, tick, sums and control state.
// Results carry a one-cycle strobe and cannot be stalled by the receiver.
`timescale 1ns / 1ps
module preemptive_priority_scheduler (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [pps_pkg::ID_W-1:0]     process_id,
    input  logic [pps_pkg::TIME_W-1:0]   arrival_time,
    input  logic [pps_pkg::TIME_W-1:0]   burst_time,
    input  logic [pps_pkg::PRI_W-1:0]    priority_level,
    input  logic                         last_process,
    output logic                         result_valid,
    output logic [pps_pkg::ID_W-1:0]     result_id,
    output logic [pps_pkg::TICK_W-1:0]   completion_time,
    output logic [pps_pkg::TICK_W-1:0]   turnaround_time,
    output logic [pps_pkg::TICK_W-1:0]   waiting_time,
    output logic [pps_pkg::SUM_W-1:0]    total_turnaround,
    output logic [pps_pkg::SUM_W-1:0]    total_waiting,
    output logic                         last_result
);

    localparam int PAD_W = pps_pkg::TICK_W - pps_pkg::TIME_W;

    pps_pkg::state_t                 state_reg, state_next;
    logic [pps_pkg::CNT_W-1:0]       loaded_reg, loaded_next;
    logic [pps_pkg::CNT_W-1:0]       finished_reg, finished_next;
    logic [pps_pkg::TICK_W-1:0]      tick_reg, tick_next;
    logic [pps_pkg::SUM_W-1:0]       tat_sum_reg, tat_sum_next;
    logic [pps_pkg::SUM_W-1:0]       wt_sum_reg, wt_sum_next;
    logic [pps_pkg::CNT_W-1:0]       iss_reg, iss_next;
    logic                            pend_reg;
    logic [pps_pkg::IDX_W-1:0]       pend_idx_reg;
    logic                            valid_reg;

    logic                            accept;
    logic                            room;
    logic                            load_we;
    logic                            issue;
    logic                            upd_we;
    logic                            dyn_we;
    logic [pps_pkg::IDX_W-1:0]       dyn_waddr;
    logic [pps_pkg::DYN_W-1:0]       dyn_wdata;
    logic [pps_pkg::REC_W-1:0]       rec_rdata;
    logic [pps_pkg::DYN_W-1:0]       dyn_rdata;

    logic [pps_pkg::ID_W-1:0]        rd_id;
    logic [pps_pkg::TIME_W-1:0]      rd_arrival;
    logic [pps_pkg::TIME_W-1:0]      rd_burst;
    logic [pps_pkg::PRI_W-1:0]       rd_priority;
    logic [pps_pkg::TIME_W-1:0]      rd_remaining;
    logic [pps_pkg::TICK_W-1:0]      rd_completion;

    pps_pkg::pps_best_t              best;
    logic [pps_pkg::TICK_W-1:0]      tick_inc;
    logic [pps_pkg::TIME_W-1:0]      rem_dec;
    logic                            rem_done;
    logic [pps_pkg::TICK_W-1:0]      upd_tat;
    logic [pps_pkg::TICK_W-1:0]      upd_wt;
    logic [pps_pkg::TICK_W-1:0]      out_tat;
    logic [pps_pkg::TICK_W-1:0]      out_wt;

    assign busy    = (state_reg != pps_pkg::ST_LOAD);
    assign accept  = start && !busy;
    assign room    = (loaded_reg < pps_pkg::CNT_W'(pps_pkg::MAX_PROC));
    assign load_we = accept && room;
    assign issue   = ((state_reg == pps_pkg::ST_SCAN) || (state_reg == pps_pkg::ST_OUT))
                     && (iss_reg < loaded_reg);
    assign upd_we  = (state_reg == pps_pkg::ST_UPD) && best.found;

    // update arithmetic for the selected process
    assign tick_inc = tick_reg + 1'b1;
    assign rem_dec  = best.remaining - 1'b1;
    assign rem_done = (rem_dec == '0);
    assign upd_tat  = tick_inc - {{PAD_W{1'b0}}, best.arrival};
    assign upd_wt   = upd_tat - {{PAD_W{1'b0}}, best.burst};

    // dynamic RAM write: initial load or service update
    assign dyn_we    = load_we || upd_we;
    assign dyn_waddr = load_we ? loaded_reg[pps_pkg::IDX_W-1:0] : best.idx;
    assign dyn_wdata = load_we ? {burst_time, {PAD_W{1'b0}}, arrival_time}
                               : {rem_dec, tick_inc};

    pps_ram #(
        .WIDTH (pps_pkg::REC_W),
        .DEPTH (pps_pkg::MAX_PROC)
    ) u_rec_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (loaded_reg[pps_pkg::IDX_W-1:0]),
        .wdata ({process_id, arrival_time, burst_time, priority_level}),
        .raddr (iss_reg[pps_pkg::IDX_W-1:0]),
        .rdata (rec_rdata)
    );

    pps_ram #(
        .WIDTH (pps_pkg::DYN_W),
        .DEPTH (pps_pkg::MAX_PROC)
    ) u_dyn_ram (
        .clk   (clk),
        .we    (dyn_we),
        .waddr (dyn_waddr),
        .wdata (dyn_wdata),
        .raddr (iss_reg[pps_pkg::IDX_W-1:0]),
        .rdata (dyn_rdata)
    );

    assign {rd_id, rd_arrival, rd_burst, rd_priority} = rec_rdata;
    assign {rd_remaining, rd_completion}               = dyn_rdata;

    pps_pick u_pick (
        .clk          (clk),
        .rst_n        (rst_n),
        .clear        (state_reg == pps_pkg::ST_UPD),
        .in_valid     (pend_reg && (state_reg == pps_pkg::ST_SCAN)),
        .in_idx       (pend_idx_reg),
        .in_arrival   (rd_arrival),
        .in_burst     (rd_burst),
        .in_priority  (rd_priority),
        .in_remaining (rd_remaining),
        .tick         (tick_reg),
        .best         (best)
    );

    // sequence load, scan, update and result phases
    always_comb
    begin
        state_next    = state_reg;
        loaded_next   = loaded_reg;
        finished_next = finished_reg;
        tick_next     = tick_reg;
        tat_sum_next  = tat_sum_reg;
        wt_sum_next   = wt_sum_reg;
        iss_next      = issue ? iss_reg + 1'b1 : iss_reg;
        case (state_reg)
            pps_pkg::ST_LOAD:
            begin
                iss_next = '0;
                if (load_we)
                begin
                    loaded_next = loaded_reg + 1'b1;
                    if (burst_time == '0)
                    begin
                        finished_next = finished_reg + 1'b1;
                    end
                end
                if (accept && last_process)
                begin
                    state_next = (finished_next == loaded_next) ? pps_pkg::ST_OUT
                                                                : pps_pkg::ST_SCAN;
                end
            end
            pps_pkg::ST_SCAN:
            begin
                if ((iss_reg == loaded_reg) && !pend_reg)
                begin
                    state_next = pps_pkg::ST_UPD;
                end
            end
            pps_pkg::ST_UPD:
            begin
                tick_next = tick_inc;
                iss_next  = '0;
                if (upd_we && rem_done)
                begin
                    finished_next = finished_reg + 1'b1;
                    tat_sum_next  = tat_sum_reg + {{(pps_pkg::SUM_W - pps_pkg::TICK_W){1'b0}},
                                                   upd_tat};
                    wt_sum_next   = wt_sum_reg + {{(pps_pkg::SUM_W - pps_pkg::TICK_W){1'b0}},
                                                  upd_wt};
                end
                state_next = (finished_next == loaded_reg) ? pps_pkg::ST_OUT
                                                           : pps_pkg::ST_SCAN;
            end
            pps_pkg::ST_OUT:
            begin
                if ((iss_reg == loaded_reg) && !pend_reg)
                begin
                    state_next    = pps_pkg::ST_LOAD;
                    loaded_next   = '0;
                    finished_next = '0;
                    tick_next     = '0;
                    tat_sum_next  = '0;
                    wt_sum_next   = '0;
                end
            end
            default:
            begin
                state_next = pps_pkg::ST_LOAD;
            end
        endcase
    end

    // advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pps_pkg::ST_LOAD;
            loaded_reg   <= '0;
            finished_reg <= '0;
            tick_reg     <= '0;
            tat_sum_reg  <= '0;
            wt_sum_reg   <= '0;
            iss_reg      <= '0;
            pend_reg     <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            loaded_reg   <= loaded_next;
            finished_reg <= finished_next;
            tick_reg     <= tick_next;
            tat_sum_reg  <= tat_sum_next;
            wt_sum_reg   <= wt_sum_next;
            iss_reg      <= iss_next;
            pend_reg     <= issue;
            valid_reg    <= pend_reg && (state_reg == pps_pkg::ST_OUT);
        end
    end

    // track the index of the read in flight
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            pend_idx_reg <= iss_reg[pps_pkg::IDX_W-1:0];
        end
    end

    // result arithmetic
    assign out_tat = rd_completion - {{PAD_W{1'b0}}, rd_arrival};
    assign out_wt  = out_tat - {{PAD_W{1'b0}}, rd_burst};

    // hold each result transaction for one cycle
    always_ff @(posedge clk)
    begin
        if (pend_reg && (state_reg == pps_pkg::ST_OUT))
        begin
            result_id        <= rd_id;
            completion_time  <= rd_completion;
            turnaround_time  <= out_tat;
            waiting_time     <= out_wt;
            total_turnaround <= tat_sum_reg;
            total_waiting    <= wt_sum_reg;
            last_result      <= ({1'b0, pend_idx_reg} == (loaded_reg - 1'b1));
        end
    end

    assign result_valid = valid_reg;

endmodule

// ===== src/pps_checker.sv =====
// Port-level checks for the preemptive priority scheduler, bound to the top level.
`timescale 1ns / 1ps
module pps_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         last_process,
    input logic                         result_valid,
    input logic [pps_pkg::TICK_W-1:0]   completion_time,
    input logic [pps_pkg::TICK_W-1:0]   turnaround_time,
    input logic [pps_pkg::TICK_W-1:0]   waiting_time,
    input logic [pps_pkg::SUM_W-1:0]    total_turnaround,
    input logic [pps_pkg::SUM_W-1:0]    total_waiting,
    input logic                         last_result
);

    // a record that is not last keeps the block ready for the next one
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !last_process) |=> !busy)
        else $error("busy after a non-final record");

    // the final result closes the batch
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_result) |=> !result_valid)
        else $error("result after the final result");

    // totals are the same on every result of a batch
    a_totals_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && $past(result_valid) && !$past(last_result))
        |-> ($stable(total_turnaround) && $stable(total_waiting)))
        else $error("batch totals changed between results");

    // waiting never exceeds turnaround, turnaround never exceeds completion
    a_time_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((waiting_time <= turnaround_time)
                          && (turnaround_time <= completion_time)))
        else $error("inconsistent result times");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .last_process     (last_process),
    .result_valid     (result_valid),
    .completion_time  (completion_time),
    .turnaround_time  (turnaround_time),
    .waiting_time     (waiting_time),
    .total_turnaround (total_turnaround),
    .total_waiting    (total_waiting),
    .last_result      (last_result)
);

// ===== tb/preemptive_priority_scheduler_checker.sv =====
// Checker for the preemptive priority scheduler: schedule prediction and result comparison.
`timescale 1ns / 1ps
module preemptive_priority_scheduler_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic [pps_pkg::ID_W-1:0]     process_id,
    input  logic [pps_pkg::TIME_W-1:0]   arrival_time,
    input  logic [pps_pkg::TIME_W-1:0]   burst_time,
    input  logic [pps_pkg::PRI_W-1:0]    priority_level,
    input  logic                         last_process,
    input  logic                         result_valid,
    input  logic [pps_pkg::ID_W-1:0]     result_id,
    input  logic [pps_pkg::TICK_W-1:0]   completion_time,
    input  logic [pps_pkg::TICK_W-1:0]   turnaround_time,
    input  logic [pps_pkg::TICK_W-1:0]   waiting_time,
    input  logic [pps_pkg::SUM_W-1:0]    total_turnaround,
    input  logic [pps_pkg::SUM_W-1:0]    total_waiting,
    input  logic                         last_result,
    output int                           fail_count,
    output int                           pending
);
    import pps_pkg::*;

    typedef struct {
        logic [ID_W-1:0]   id;
        logic [TICK_W-1:0] done;
        logic [TICK_W-1:0] tat;
        logic [TICK_W-1:0] wt;
        logic [SUM_W-1:0]  tat_sum;
        logic [SUM_W-1:0]  wt_sum;
        logic              last;
    } sched_result_t;

    // loaded batch
    logic [ID_W-1:0]   batch_id   [MAX_PROC];
    logic [TIME_W-1:0] batch_arr  [MAX_PROC];
    logic [TIME_W-1:0] batch_burst[MAX_PROC];
    logic [PRI_W-1:0]  batch_pri  [MAX_PROC];
    int                batch_len;

    sched_result_t sched_q[$];

    initial begin
        fail_count = 0;
        pending    = 0;
        batch_len  = 0;
    end

    // Run the tick-by-tick schedule over the batch and queue one result per record
    function automatic void predict_schedule();
        logic [TIME_W-1:0] rem [MAX_PROC];
        logic [TICK_W-1:0] done[MAX_PROC];
        logic [TICK_W-1:0] tick;
        logic [TICK_W-1:0] tat;
        logic [SUM_W-1:0]  tat_sum;
        logic [SUM_W-1:0]  wt_sum;
        int                finished;
        int                best;
        bit                found;
        sched_result_t     r;
        tick = '0;
        tat_sum = '0;
        wt_sum = '0;
        finished = 0;
        for (int k = 0; k < batch_len; k++) begin
            rem[k] = batch_burst[k];
            done[k] = TICK_W'(batch_arr[k]);
            if (rem[k] == 0) finished++;
        end
        while (finished < batch_len) begin
            found = 0;
            best = 0;
            for (int k = 0; k < batch_len; k++) begin
                if (TICK_W'(batch_arr[k]) <= tick && rem[k] != 0) begin
                    if (!found || batch_pri[k] > batch_pri[best] ||
                        (batch_pri[k] == batch_pri[best] &&
                         batch_arr[k] < batch_arr[best])) begin
                        found = 1;
                        best = k;
                    end
                end
            end
            tick = tick + 1'b1;
            if (found) begin
                rem[best] = rem[best] - 1'b1;
                if (rem[best] == 0) begin
                    done[best] = tick;
                    finished++;
                end
            end
        end
        // totals are order independent, so sum once all are done
        for (int k = 0; k < batch_len; k++) begin
            tat = done[k] - TICK_W'(batch_arr[k]);
            tat_sum = tat_sum + SUM_W'(tat);
            wt_sum = wt_sum + SUM_W'(TICK_W'(tat - TICK_W'(batch_burst[k])));
        end
        for (int k = 0; k < batch_len; k++) begin
            r.id = batch_id[k];
            r.done = done[k];
            r.tat = done[k] - TICK_W'(batch_arr[k]);
            r.wt = r.tat - TICK_W'(batch_burst[k]);
            r.tat_sum = tat_sum;
            r.wt_sum = wt_sum;
            r.last = (k + 1 == batch_len);
            sched_q.push_back(r);
        end
        batch_len = 0;
    endfunction

    function automatic void compare_field(string name, longint unsigned exp_v,
                                          longint unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // Check results, then capture accepted records
    always @(posedge clk or negedge rst_n) begin
        sched_result_t e;
        if (!rst_n) begin
            batch_len = 0;
        end
        else begin
            if (result_valid) begin
                if (sched_q.size() == 0) begin
                    $display("%0t: unexpected result, actual id %0d", $time, result_id);
                    fail_count++;
                end
                else begin
                    e = sched_q.pop_front();
                    compare_field("result_id", e.id, result_id);
                    compare_field("completion_time", e.done, completion_time);
                    compare_field("turnaround_time", e.tat, turnaround_time);
                    compare_field("waiting_time", e.wt, waiting_time);
                    compare_field("total_turnaround", e.tat_sum, total_turnaround);
                    compare_field("total_waiting", e.wt_sum, total_waiting);
                    compare_field("last_result", e.last, last_result);
                end
            end
            if (start && !busy) begin
                // drop records past a full table
                if (batch_len < MAX_PROC) begin
                    batch_id[batch_len] = process_id;
                    batch_arr[batch_len] = arrival_time;
                    batch_burst[batch_len] = burst_time;
                    batch_pri[batch_len] = priority_level;
                    batch_len++;
                end
                if (last_process) predict_schedule();
            end
        end
        pending = sched_q.size();
    end

endmodule

// ===== tb/preemptive_priority_scheduler_test.sv =====
// Testbench top for the preemptive priority scheduler: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module preemptive_priority_scheduler_test;
    import pps_pkg::*;

    logic                clk = 0;
    logic                rst_n = 0;
    logic                start = 0;
    logic                busy;
    logic [ID_W-1:0]     process_id = '0;
    logic [TIME_W-1:0]   arrival_time = '0;
    logic [TIME_W-1:0]   burst_time = '0;
    logic [PRI_W-1:0]    priority_level = '0;
    logic                last_process = 0;
    logic                result_valid;
    logic [ID_W-1:0]     result_id;
    logic [TICK_W-1:0]   completion_time;
    logic [TICK_W-1:0]   turnaround_time;
    logic [TICK_W-1:0]   waiting_time;
    logic [SUM_W-1:0]    total_turnaround;
    logic [SUM_W-1:0]    total_waiting;
    logic                last_result;
    int                  fail_count;
    int                  pending;

    int  sent;
    bit  idling_on;
    bit  drained_once;

    always #6 clk = ~clk;

    preemptive_priority_scheduler DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .process_id(process_id), .arrival_time(arrival_time), .burst_time(burst_time),
        .priority_level(priority_level), .last_process(last_process),
        .result_valid(result_valid), .result_id(result_id),
        .completion_time(completion_time), .turnaround_time(turnaround_time),
        .waiting_time(waiting_time), .total_turnaround(total_turnaround),
        .total_waiting(total_waiting), .last_result(last_result)
    );

    preemptive_priority_scheduler_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .process_id(process_id), .arrival_time(arrival_time), .burst_time(burst_time),
        .priority_level(priority_level), .last_process(last_process),
        .result_valid(result_valid), .result_id(result_id),
        .completion_time(completion_time), .turnaround_time(turnaround_time),
        .waiting_time(waiting_time), .total_turnaround(total_turnaround),
        .total_waiting(total_waiting), .last_result(last_result),
        .fail_count(fail_count), .pending(pending)
    );

    // Present one record and hold it until the block takes the transaction
    task automatic send_record(logic [ID_W-1:0] id, logic [TIME_W-1:0] arr,
                               logic [TIME_W-1:0] burst, logic [PRI_W-1:0] pri,
                               logic last);
        int gap;
        gap = 0;
        while (idling_on && $urandom_range(99) < 26)
        begin
            gap++;
        end
        if (gap != 0)
        begin
            start <= 0;
            repeat (gap) @(posedge clk);
        end
        start <= 1;
        process_id <= id;
        arrival_time <= arr;
        burst_time <= burst;
        priority_level <= pri;
        last_process <= last;
        do @(negedge clk); while (busy);
        @(posedge clk);
        sent++;
    endtask

    // Drop start and wait until every expected result has come
    task automatic wait_drained();
        start <= 0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    // Random batch: mostly short, some near full, full or overfull, rare huge times
    task automatic send_batch();
        int                len;
        bit                huge;
        bit                tie_pri;
        int                roll;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] arr;
        logic [TIME_W-1:0] burst;
        logic [PRI_W-1:0]  pri;
        roll = $urandom_range(99);
        huge = (roll < 4);
        tie_pri = 1'($urandom_range(1));
        if (huge)
            len = 1;
        else if (roll < 14)
            len = $urandom_range(15, 18);
        else
            len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
        begin
            id = ID_W'($urandom_range(255));
            arr = huge ? TIME_W'($urandom_range(4095)) : TIME_W'($urandom_range(30));
            if (huge)
                burst = TIME_W'($urandom_range(4095));
            else if ($urandom_range(9) == 0)
                burst = '0;
            else
                burst = TIME_W'($urandom_range(1, 12));
            pri = tie_pri ? PRI_W'($urandom_range(3)) : PRI_W'($urandom_range(255));
            send_record(id, arr, burst, pri, i == len - 1);
        end
    endtask

    initial
    begin
        sent = 0;
        idling_on = 1;
        drained_once = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Largest fields, single record
        send_record(8'd255, 12'd4095, 12'd4095, 8'd255, 1);
        // Ties on priority and arrival, zero burst, zero priority and id
        send_record(8'd0, 12'd0, 12'd3, 8'd5, 0);
        send_record(8'd2, 12'd0, 12'd0, 8'd7, 0);
        send_record(8'd3, 12'd1, 12'd2, 8'd5, 0);
        send_record(8'd4, 12'd1, 12'd2, 8'd9, 0);
        send_record(8'd5, 12'd6, 12'd1, 8'd0, 1);
        // Table overflow: the record marked last is dropped but still starts the run
        for (int i = 0; i < 17; i++)
        begin
            send_record(8'(i + 16), 12'(i * 3), 12'(i % 4), 8'(i % 3), i == 16);
        end

        while (sent < 100)
        begin
            idling_on = !(sent >= 50 && sent < 85);
            if (!drained_once && sent >= 70)
            begin
                wait_drained();
                drained_once = 1;
            end
            send_batch();
        end
        start <= 0;
        wait_drained();
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #60_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
